[hw/rtl/wsd_pkg.sv]
// Shared types and constants for the websocket frame deframer.
package wsd_pkg;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_PAYLOAD    = 3'd0,
        KIND_EMPTY      = 3'd1,
        KIND_SEND_PONG  = 3'd2,
        KIND_SEND_CLOSE = 3'd3,
        KIND_CLOSE_CONN = 3'd4
    } wsd_kind_t;

    // Input operation codes
    localparam logic OP_RX_BYTE   = 1'b0;
    localparam logic OP_CONS_ERR  = 1'b1;

    // Frame opcodes with special handling
    localparam logic [3:0] OPC_CLOSE = 4'h8;
    localparam logic [3:0] OPC_PING  = 4'h9;

    // 7-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Header byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // One classified transaction waiting for the back end
    typedef struct packed {
        wsd_kind_t  kind;
        logic [7:0] data;    // still masked
        logic [7:0] key;     // mask byte to apply, zero when not a payload byte
        logic       fin;
        logic [3:0] opcode;
        logic       last;
    } wsd_entry_t;

endpackage

[hw/rtl/wsd_parser.sv]
// Front end: header parser, close tracking and result classification.
module wsd_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic                operation,
    input  logic [7:0]          rx_byte,
    output logic                push,
    output wsd_pkg::wsd_entry_t entry
);
    import wsd_pkg::*;

    typedef enum logic [4:0] {
        PH_FIRST   = 5'b00001,
        PH_SECOND  = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_KEY     = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef enum logic [3:0] {
        CS_OPEN     = 4'b0001,
        CS_ANSWERED = 4'b0010,
        CS_OUR_SENT = 4'b0100,
        CS_ENDED    = 4'b1000
    } close_t;

    phase_t      phase_reg, phase_next;
    close_t      close_reg, close_next;
    logic        held_fin_reg, held_fin_next;
    logic [3:0]  held_opc_reg, held_opc_next;
    logic        masked_reg, masked_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [31:0] key_reg, key_next;
    logic [63:0] rem_reg, rem_next;
    logic [1:0]  idx_reg, idx_next;

    logic        length_end;
    logic        header_end;
    logic        frame_end;
    logic        masked_now;
    logic        last_byte;
    logic        data_frame;
    logic        early_close;
    logic [63:0] rem_new;
    logic [7:0]  key_byte;

    assign data_frame  = (held_opc_reg != OPC_CLOSE) && (held_opc_reg != OPC_PING);
    assign early_close = (close_reg == CS_OPEN) || (close_reg == CS_ANSWERED);
    assign last_byte   = (rem_reg == 64'd1);

    // Mask byte for the current payload position
    always_comb begin
        case (idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    // Parse step for one accepted transaction
    always_comb begin
        phase_next    = phase_reg;
        close_next    = close_reg;
        held_fin_next = held_fin_reg;
        held_opc_next = held_opc_reg;
        masked_next   = masked_reg;
        cnt_next      = cnt_reg;
        key_next      = key_reg;
        rem_next      = rem_reg;
        idx_next      = idx_reg;
        length_end    = 1'b0;
        header_end    = 1'b0;
        frame_end     = 1'b0;
        masked_now    = masked_reg;
        rem_new       = rem_reg;
        push          = 1'b0;
        entry.kind    = KIND_PAYLOAD;
        entry.data    = 8'h00;
        entry.key     = 8'h00;
        entry.fin     = held_fin_reg;
        entry.opcode  = held_opc_reg;
        entry.last    = 1'b0;

        if (accept && (close_reg != CS_ENDED)) begin
            if (operation == OP_CONS_ERR) begin
                if (early_close) begin
                    close_next   = CS_OUR_SENT;
                    push         = 1'b1;
                    entry.kind   = KIND_SEND_CLOSE;
                    entry.fin    = 1'b0;
                    entry.opcode = 4'h0;
                end
            end else begin
                unique case (phase_reg)
                    PH_SECOND: begin
                        masked_next = rx_byte[7];
                        masked_now  = rx_byte[7];
                        key_next    = 32'h0;
                        rem_next    = 64'h0;
                        if (rx_byte[6:0] == LEN_EXT16) begin
                            cnt_next   = EXT16_BYTES;
                            phase_next = PH_EXTLEN;
                        end else if (rx_byte[6:0] == LEN_EXT64) begin
                            cnt_next   = EXT64_BYTES;
                            phase_next = PH_EXTLEN;
                        end else begin
                            rem_next   = {57'h0, rx_byte[6:0]};
                            rem_new    = {57'h0, rx_byte[6:0]};
                            length_end = 1'b1;
                        end
                    end
                    PH_EXTLEN: begin
                        rem_next = {rem_reg[55:0], rx_byte};
                        rem_new  = {rem_reg[55:0], rx_byte};
                        cnt_next = cnt_reg - 4'd1;
                        if (cnt_reg == 4'd1) begin
                            length_end = 1'b1;
                        end
                    end
                    PH_KEY: begin
                        key_next = {key_reg[23:0], rx_byte};
                        cnt_next = cnt_reg - 4'd1;
                        if (cnt_reg == 4'd1) begin
                            header_end = 1'b1;
                        end
                    end
                    PH_PAYLOAD: begin
                        idx_next = idx_reg + 2'd1;
                        rem_next = rem_reg - 64'd1;
                        if (data_frame) begin
                            if (last_byte) begin
                                phase_next = PH_FIRST;
                            end
                            if (early_close) begin
                                push       = 1'b1;
                                entry.kind = KIND_PAYLOAD;
                                entry.data = rx_byte;
                                entry.key  = key_byte;
                                entry.last = last_byte;
                            end
                        end else if (last_byte) begin
                            frame_end = 1'b1;
                        end
                    end
                    default: begin
                        held_fin_next = rx_byte[7];
                        held_opc_next = rx_byte[3:0];
                        phase_next    = PH_SECOND;
                    end
                endcase

                // Length known: a mask key follows or the header is complete
                if (length_end) begin
                    if (masked_now) begin
                        cnt_next   = KEY_BYTES;
                        phase_next = PH_KEY;
                    end else begin
                        header_end = 1'b1;
                    end
                end

                if (header_end) begin
                    idx_next = 2'd0;
                    if (rem_new == 64'h0) begin
                        frame_end = 1'b1;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end

                // End-of-frame event
                if (frame_end) begin
                    phase_next = PH_FIRST;
                    entry.last = 1'b1;
                    if (held_opc_reg == OPC_CLOSE) begin
                        if (close_reg == CS_OPEN) begin
                            close_next = CS_ANSWERED;
                            push       = 1'b1;
                            entry.kind = KIND_SEND_CLOSE;
                        end else if (close_reg == CS_OUR_SENT) begin
                            close_next = CS_ENDED;
                            push       = 1'b1;
                            entry.kind = KIND_CLOSE_CONN;
                        end
                    end else if (held_opc_reg == OPC_PING) begin
                        if (close_reg == CS_OPEN) begin
                            push       = 1'b1;
                            entry.kind = KIND_SEND_PONG;
                        end
                    end else if (early_close) begin
                        push       = 1'b1;
                        entry.kind = KIND_EMPTY;
                    end
                end
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_FIRST;
            close_reg     <= CS_OPEN;
            held_fin_reg  <= 1'b0;
            held_opc_reg  <= 4'h0;
            masked_reg    <= 1'b0;
            cnt_reg       <= 4'h0;
            key_reg       <= 32'h0;
            rem_reg       <= 64'h0;
            idx_reg       <= 2'd0;
        end else begin
            phase_reg     <= phase_next;
            close_reg     <= close_next;
            held_fin_reg  <= held_fin_next;
            held_opc_reg  <= held_opc_next;
            masked_reg    <= masked_next;
            cnt_reg       <= cnt_next;
            key_reg       <= key_next;
            rem_reg       <= rem_next;
            idx_reg       <= idx_next;
        end
    end

    // Once the connection has ended it stays ended
    a_ended_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        close_reg == CS_ENDED |=> close_reg == CS_ENDED)
        else $error("close state left ended");

    // Closing the connection only follows our own close
    a_close_conn_src: assert property (@(posedge aclk) disable iff (!aresetn)
        push && entry.kind == KIND_CLOSE_CONN |-> close_reg == CS_OUR_SENT)
        else $error("close connection without our close sent");

    // Payload bytes come only from the payload phase of a data frame
    a_payload_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        push && entry.kind == KIND_PAYLOAD |-> phase_reg == PH_PAYLOAD && data_frame)
        else $error("payload byte outside payload phase");

endmodule

[hw/rtl/wsd_queue.sv]
// Short queue between the parser and the output stage.
module wsd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  wsd_pkg::wsd_entry_t push_entry,
    input  logic                pop,
    output logic                not_empty,
    output logic                not_full,
    output wsd_pkg::wsd_entry_t head
);
    import wsd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    wsd_entry_t       store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign not_empty = (cnt_reg != '0);
    assign not_full  = (cnt_reg != CNT_W'(DEPTH));
    assign head      = store_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> not_full || pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("queue underflow");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("queue count did not advance on push");

endmodule

[hw/rtl/wsd_unmask.sv]
// Back end: unmasks payload bytes and holds the result register.
module wsd_unmask (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_not_empty,
    input  wsd_pkg::wsd_entry_t q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_kind,
    output logic [7:0]          m_data_byte,
    output logic                m_fin,
    output logic [3:0]          m_frame_opcode,
    output logic                m_last_of_frame
);
    import wsd_pkg::*;

    logic       valid_reg;
    logic [2:0] kind_reg;
    logic [7:0] data_reg;
    logic       fin_reg;
    logic [3:0] opc_reg;
    logic       last_reg;

    // Load a new result when the register is empty or being drained
    assign q_pop = q_not_empty && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (q_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            kind_reg <= q_head.kind;
            data_reg <= q_head.data ^ q_head.key;
            fin_reg  <= q_head.fin;
            opc_reg  <= q_head.opcode;
            last_reg <= q_head.last;
        end
    end

    assign m_valid         = valid_reg;
    assign m_kind          = kind_reg;
    assign m_data_byte     = data_reg;
    assign m_fin           = fin_reg;
    assign m_frame_opcode  = opc_reg;
    assign m_last_of_frame = last_reg;

endmodule

[hw/rtl/websocket_frame_deframer_top.sv]
// A result is written into the queue storage, then loaded into the output register on m_*.
// Throughput: one input transaction per cycle while the result side keeps up;
//   the parser, the queue and the output register each take one step per cycle.
// The input stalls only when the queue between parser and output stage is full.
// Reset (aresetn low at a clock edge) returns the parser to the first header byte,
//   the connection to open, and empties the queue and the output register.
module websocket_frame_deframer_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_operation,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic       m_fin,
    output logic [3:0] m_frame_opcode,
    output logic       m_last_of_frame
);
    import wsd_pkg::*;

    logic       accept;
    logic       push;
    wsd_entry_t push_entry;
    logic       pop;
    logic       q_not_empty;
    logic       q_not_full;
    wsd_entry_t q_head;

    assign s_ready = q_not_full;
    assign accept  = s_valid && s_ready;

    wsd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .operation (s_operation),
        .rx_byte   (s_rx_byte),
        .push      (push),
        .entry     (push_entry)
    );

    wsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .not_empty  (q_not_empty),
        .not_full   (q_not_full),
        .head       (q_head)
    );

    wsd_unmask u_unmask (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data_byte     (m_data_byte),
        .m_fin           (m_fin),
        .m_frame_opcode  (m_frame_opcode),
        .m_last_of_frame (m_last_of_frame)
    );

endmodule

[tb/sv/tb_websocket_frame_deframer_top.sv]
// Self-checking testbench for the websocket frame deframer top level.
`timescale 1ns / 100ps

module tb_websocket_frame_deframer_top;
    import wsd_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_AT      = 3000;
    localparam int HOLD_LEN     = 500;

    // Parser phases
    localparam logic [2:0] PH_HDR0    = 3'd0;
    localparam logic [2:0] PH_HDR1    = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    // Connection close states
    localparam logic [1:0] CS_OPEN        = 2'd0;
    localparam logic [1:0] CS_PEER_CLOSED = 2'd1;
    localparam logic [1:0] CS_OUR_CLOSE   = 2'd2;
    localparam logic [1:0] CS_ENDED       = 2'd3;

    typedef struct packed {
        wsd_kind_t  kind;
        logic [7:0] data;
        logic       fin;
        logic [3:0] opcode;
        logic       last;
    } deframed_t;

    typedef struct packed {
        logic       op;
        logic [7:0] b;
        logic       hold;     // wait for all outstanding results before sending
    } rx_item_t;

    logic       aclk    = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_operation = OP_RX_BYTE;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_kind;
    logic [7:0] m_data_byte;
    logic       m_fin;
    logic [3:0] m_frame_opcode;
    logic       m_last_of_frame;

    rx_item_t  rx_stream[$];
    deframed_t deframed_due[$];
    logic      hold_next = 1'b0;
    int        n_err = 0;
    int        tx_gap = 0;
    int        tx_calm = 0;
    int        rx_gap = 0;
    int        rx_calm = 0;
    int        hold_left = 0;
    int        sink_cycles = 0;
    int        cycles = 0;

    // Predictor state
    logic [2:0]  phase = PH_HDR0;
    logic        hdr_fin = 1'b0;
    logic [3:0]  hdr_opc = 4'h0;
    logic        masked = 1'b0;
    logic [3:0]  hdr_left = 4'd0;
    logic [31:0] key = 32'h0;
    logic [63:0] remaining = 64'h0;
    logic [1:0]  key_idx = 2'd0;
    logic [1:0]  conn = CS_OPEN;

    websocket_frame_deframer_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data_byte     (m_data_byte),
        .m_fin           (m_fin),
        .m_frame_opcode  (m_frame_opcode),
        .m_last_of_frame (m_last_of_frame)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // Event at the end of a frame: close/ping handling or an empty data frame
    function automatic bit end_of_frame(output deframed_t r);
        bit hit = 1'b0;
        r = '{kind: KIND_PAYLOAD, data: 8'h00, fin: hdr_fin, opcode: hdr_opc, last: 1'b1};
        phase = PH_HDR0;
        if (hdr_opc == OPC_CLOSE) begin
            if (conn == CS_OPEN) begin
                conn = CS_PEER_CLOSED;
                r.kind = KIND_SEND_CLOSE;
                hit = 1'b1;
            end else if (conn == CS_OUR_CLOSE) begin
                conn = CS_ENDED;
                r.kind = KIND_CLOSE_CONN;
                hit = 1'b1;
            end
        end else if (hdr_opc == OPC_PING) begin
            if (conn == CS_OPEN) begin
                r.kind = KIND_SEND_PONG;
                hit = 1'b1;
            end
        end else if (conn == CS_OPEN || conn == CS_PEER_CLOSED) begin
            r.kind = KIND_EMPTY;
            hit = 1'b1;
        end
        return hit;
    endfunction

    // Header complete: go to payload, or close out an empty frame
    function automatic bit header_complete(output deframed_t r);
        r = '0;
        key_idx = 2'd0;
        if (remaining == 64'h0)
            return end_of_frame(r);
        phase = PH_PAYLOAD;
        return 1'b0;
    endfunction

    // Length known: fetch the mask key if the frame is masked
    function automatic bit length_complete(output deframed_t r);
        r = '0;
        if (masked) begin
            hdr_left = KEY_BYTES;
            phase = PH_KEY;
            return 1'b0;
        end
        return header_complete(r);
    endfunction

    // One accepted transaction through the deframer; returns 1 if it yields a result
    function automatic bit deframe_step(input logic op, input logic [7:0] b,
                                        output deframed_t r);
        bit hit = 1'b0;
        logic [7:0] plain;
        r = '0;
        if (conn == CS_ENDED)
            return 1'b0;
        if (op == OP_CONS_ERR) begin
            if (conn == CS_OUR_CLOSE)
                return 1'b0;
            conn = CS_OUR_CLOSE;
            r.kind = KIND_SEND_CLOSE;
            return 1'b1;
        end
        case (phase)
            PH_HDR1: begin
                masked = b[7];
                key = 32'h0;
                remaining = 64'h0;
                if (b[6:0] == LEN_EXT16) begin
                    hdr_left = EXT16_BYTES;
                    phase = PH_EXTLEN;
                end else if (b[6:0] == LEN_EXT64) begin
                    hdr_left = EXT64_BYTES;
                    phase = PH_EXTLEN;
                end else begin
                    remaining = 64'(b[6:0]);
                    hit = length_complete(r);
                end
            end
            PH_EXTLEN: begin
                remaining = {remaining[55:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    hit = length_complete(r);
            end
            PH_KEY: begin
                key = {key[23:0], b};
                hdr_left = hdr_left - 4'd1;
                if (hdr_left == 4'd0)
                    hit = header_complete(r);
            end
            PH_PAYLOAD: begin
                plain = b ^ key[8 * (3 - key_idx) +: 8];
                key_idx = key_idx + 2'd1;
                remaining = remaining - 64'd1;
                if (hdr_opc != OPC_CLOSE && hdr_opc != OPC_PING) begin
                    if (remaining == 64'h0)
                        phase = PH_HDR0;
                    if (conn == CS_OPEN || conn == CS_PEER_CLOSED) begin
                        r = '{kind: KIND_PAYLOAD, data: plain, fin: hdr_fin,
                              opcode: hdr_opc, last: remaining == 64'h0};
                        hit = 1'b1;
                    end
                end else if (remaining == 64'h0) begin
                    hit = end_of_frame(r);
                end
            end
            default: begin
                hdr_fin = b[7];
                hdr_opc = b[3:0];
                phase = PH_HDR1;
            end
        endcase
        return hit;
    endfunction

    // ---------------------------------------------------------------- stimulus

    // Mostly back-to-back, some short gaps, rare long ones, and calm stretches
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 5) begin
            calm = $urandom_range(40, 200);
            return 0;
        end
        if (r < 600) return 0;
        if (r < 900) return $urandom_range(1, 3);
        if (r < 985) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic put(input logic op, input logic [7:0] b);
        rx_stream.push_back('{op: op, b: b, hold: hold_next});
        hold_next = 1'b0;
    endtask

    // Build one frame; optionally slip a consumer error in at a random point
    task automatic add_frame(input logic [3:0] opc, input int unsigned len, input bit with_err);
        logic [7:0]  hb[$];
        logic [63:0] len64;
        logic        masked_f;
        int          sel;
        int          at;
        len64 = 64'(len);
        masked_f = 1'($urandom);
        sel = (len > 125) ? $urandom_range(0, 1) : $urandom_range(0, 9);
        hb.push_back({1'($urandom), 3'($urandom), opc});
        if (sel == 0) begin
            hb.push_back({masked_f, LEN_EXT16});
            hb.push_back(len64[15:8]);
            hb.push_back(len64[7:0]);
        end else if (sel == 1) begin
            hb.push_back({masked_f, LEN_EXT64});
            for (int i = 7; i >= 0; i--)
                hb.push_back(len64[8 * i +: 8]);
        end else begin
            hb.push_back({masked_f, len64[6:0]});
        end
        if (masked_f)
            repeat (4) hb.push_back(8'($urandom));
        repeat (len) hb.push_back(8'($urandom));
        at = with_err ? $urandom_range(0, hb.size()) : -1;
        foreach (hb[i]) begin
            if (i == at)
                put(OP_CONS_ERR, 8'($urandom));
            put(OP_RX_BYTE, hb[i]);
        end
        if (at == hb.size())
            put(OP_CONS_ERR, 8'($urandom));
    endtask

    function automatic int unsigned pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 0;
        if (r < 85) return $urandom_range(1, 12);
        if (r < 97) return $urandom_range(13, 125);
        return $urandom_range(126, 300);
    endfunction

    // Random data or ping frame; close frames only come from the close script
    task automatic random_frame(input bit with_err);
        logic [3:0] o;
        o = 4'($urandom);
        if (o == OPC_CLOSE)
            o = OPC_PING;
        add_frame(o, pick_len(), with_err);
    endtask

    // ---------------------------------------------------------------- driver

    always @(posedge aclk) begin : drive
        rx_item_t  nxt;
        deframed_t ev;
        bit        offering;
        if (aresetn) begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                if (deframe_step(s_operation, s_rx_byte, ev))
                    deframed_due.push_back(ev);
                offering = 1'b0;
            end
            if (!offering) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (rx_stream.size() > 0 &&
                             !(rx_stream[0].hold && deframed_due.size() > 0)) begin
                    nxt = rx_stream.pop_front();
                    s_valid     <= 1'b1;
                    s_operation <= nxt.op;
                    s_rx_byte   <= nxt.b;
                    tx_gap = pick_gap(tx_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    // Random stalls plus one long hold-off to back the block up
    always @(posedge aclk) begin : sink
        sink_cycles++;
        if (sink_cycles == HOLD_AT)
            hold_left = HOLD_LEN;
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_ready <= 1'b0;
        end else begin
            rx_gap = pick_gap(rx_calm);
            m_ready <= 1'b1;
        end
    end

    task automatic flag_field(input string field, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            n_err++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endtask

    // Compare each result transaction with the oldest prediction
    always @(posedge aclk) begin : check
        deframed_t want;
        if (aresetn && m_valid && m_ready) begin
            if (deframed_due.size() == 0) begin
                n_err++;
                $display("%0t: unexpected result expected none actual kind %0d data %0h",
                         $time, m_kind, m_data_byte);
            end else begin
                want = deframed_due.pop_front();
                flag_field("kind", 8'(want.kind), 8'(m_kind));
                flag_field("data_byte", want.data, m_data_byte);
                flag_field("fin", 8'(want.fin), 8'(m_fin));
                flag_field("frame_opcode", 8'(want.opcode), 8'(m_frame_opcode));
                flag_field("last_of_frame", 8'(want.last), 8'(m_last_of_frame));
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_websocket_frame_deframer_top: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin : run
        static logic [7:0] opening[] = '{
            8'h81, 8'h00,                                  // empty final text frame
            8'h70, 8'h01, 8'hFF,                           // RSV set, fin 0, one byte
            8'h89, 8'h81, 8'hA5, 8'h5A, 8'h0F, 8'hF0, 8'h33, // masked ping
            8'h0F, 8'h7E, 8'h00, 8'h02, 8'h00, 8'hFF,      // 16-bit length
            8'h8F, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00,      // 64-bit length
            8'h00, 8'h00, 8'h00, 8'h01, 8'h5A
        };
        foreach (opening[i])
            put(OP_RX_BYTE, opening[i]);

        // Random traffic on an open connection, then a full drain, then more
        while (rx_stream.size() < 1500)
            random_frame(1'b0);
        hold_next = 1'b1;
        while (rx_stream.size() < 1900)
            random_frame(1'b0);

        // Close handshake: peer close first, or straight to our own close
        if ($urandom_range(0, 1)) begin
            add_frame(OPC_CLOSE, $urandom_range(0, 6), 1'b0);
            add_frame(OPC_PING, $urandom_range(0, 4), 1'b0);
            repeat ($urandom_range(2, 5)) random_frame(1'b0);
            add_frame(OPC_CLOSE, $urandom_range(0, 6), 1'b0);
        end
        random_frame(1'b1);
        add_frame(OPC_PING, $urandom_range(0, 4), 1'b0);
        add_frame(4'h2, 0, 1'b0);
        repeat ($urandom_range(2, 5)) random_frame(1'b0);
        put(OP_CONS_ERR, 8'($urandom));
        add_frame(OPC_CLOSE, $urandom_range(0, 6), 1'b0);

        // Connection ended: everything after this is ignored
        repeat (40)
            put(($urandom_range(0, 3) == 0) ? OP_CONS_ERR : OP_RX_BYTE, 8'($urandom));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (rx_stream.size() > 0 || s_valid || deframed_due.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (deframed_due.size() != 0) begin
            n_err++;
            $display("%0t: results left over expected 0 actual %0d",
                     $time, deframed_due.size());
        end
        if (n_err == 0)
            $display("tb_websocket_frame_deframer_top: clean");
        else
            $display("tb_websocket_frame_deframer_top: errors");
        $finish;
    end

endmodule
